[rtl/qcmr_pkg.sv]
package qcmr_pkg;

   // word field widths
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = 40;
   localparam int FRAC_W    = 5;

   // longest term group that the random test sends
   localparam int TERMS_MAX = 16;

   // rescale datapath: shift amount is a signed count, magnitude clamped
   localparam int SHIFT_W       = 7;
   localparam int MAG_W         = 5;
   localparam int SHIFT_CAP     = 30;
   localparam int LSH_LIMIT_LOG = 50;
   localparam int SCALE_W       = LSH_LIMIT_LOG + 2;
   localparam int TOTAL_W       = SCALE_W + 1;

   // int16 saturation bounds
   localparam int RES_MAX = 32767;
   localparam int RES_MIN = -32768;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_FRAC  = 2'd0,
      CSR_ACT_IN_FRAC  = 2'd1,
      CSR_ACT_OUT_FRAC = 2'd2,
      CSR_BIAS_FRAC    = 2'd3
   } csr_index_type;

   typedef logic signed [SCALE_W-1:0] scale_type;
   typedef logic signed [SHIFT_W-1:0] shift_type;

endpackage

[rtl/qcmr_rescale.sv]
module qcmr_rescale
   import qcmr_pkg::*;
(
   input  scale_type x,
   input  shift_type sh,
   output scale_type y
);

   localparam scale_type LSH_LIMIT = SCALE_W'(1) << LSH_LIMIT_LOG;

   logic      right;
   shift_type mag_full;
   logic [MAG_W-1:0] mag;
   scale_type half;
   scale_type rounded;
   scale_type lim;

   // clamp the shift magnitude
   always_comb begin
      right    = (sh > shift_type'(0));
      mag_full = right ? sh : -sh;
      mag      = (mag_full > SHIFT_W'(SHIFT_CAP)) ? MAG_W'(SHIFT_CAP) : mag_full[MAG_W-1:0];
   end

   // right shift rounds half up, left shift saturates at the limit
   always_comb begin
      half    = SCALE_W'(1) << (mag - MAG_W'(1));
      rounded = x + half;
      lim     = LSH_LIMIT >>> mag;
      if (right) begin
         y = rounded >>> mag;
      end else if (x > lim) begin
         y = LSH_LIMIT;
      end else if (x < -lim) begin
         y = -LSH_LIMIT;
      end else begin
         y = x <<< mag;
      end
   end

endmodule

[rtl/quantized_conv_mac_rescale_top.sv]
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | weight, activation, flags, bias, prior
// rsp     | out       | rsp_valid / rsp_ready | result
// csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// one word accepted per cycle while req_ready is high; five register stages:
// input, product, running sum, rescale, output, the last of which drives rsp
// words that are not marked last leave no result and drain after the sum stage
// reset is synchronous and clears the valid bits, the running sum and the csrs
// a stalled rsp backs up stage by stage; bubbles ahead of it keep taking words
module quantized_conv_mac_rescale_top
   import qcmr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_weight,
   input  logic signed [DATA_W-1:0] req_activation,
   input  logic                     req_first_term,
   input  logic                     req_last_term,
   input  logic                     req_use_bias,
   input  logic signed [DATA_W-1:0] req_bias,
   input  logic signed [DATA_W-1:0] req_prior_output,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_result,

   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [FRAC_W-1:0]        csr_wdata
);

   // configuration registers
   logic [FRAC_W-1:0] weight_frac_ff;
   logic [FRAC_W-1:0] act_in_frac_ff;
   logic [FRAC_W-1:0] act_out_frac_ff;
   logic [FRAC_W-1:0] bias_frac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_frac_ff  <= '0;
         act_in_frac_ff  <= '0;
         act_out_frac_ff <= '0;
         bias_frac_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_WEIGHT_FRAC:  weight_frac_ff  <= csr_wdata;
            CSR_ACT_IN_FRAC:  act_in_frac_ff  <= csr_wdata;
            CSR_ACT_OUT_FRAC: act_out_frac_ff <= csr_wdata;
            CSR_BIAS_FRAC:    bias_frac_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shift amounts, positive means right
   shift_type out_sh;
   shift_type bias_sh;

   assign out_sh  = shift_type'({2'b00, act_in_frac_ff}) + shift_type'({2'b00, weight_frac_ff})
                  - shift_type'({2'b00, act_out_frac_ff});
   assign bias_sh = shift_type'({2'b00, bias_frac_ff}) - shift_type'({2'b00, act_out_frac_ff});

   // stage registers
   logic                     s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   logic signed [DATA_W-1:0] s1_weight_ff, s1_act_ff, s1_bias_ff, s1_prior_ff;
   logic                     s1_first_ff, s1_last_ff, s1_use_bias_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic signed [DATA_W-1:0] s2_bias_ff, s2_prior_ff;
   logic                     s2_first_ff, s2_last_ff, s2_use_bias_ff;
   logic signed [SUM_W-1:0]  run_ff;
   logic signed [DATA_W-1:0] s3_bias_ff, s3_prior_ff;
   logic                     s3_last_ff, s3_use_bias_ff;
   scale_type                s4_scaled_ff, s4_base_ff;
   logic signed [DATA_W-1:0] result_ff;

   // stage advance chain, back from the output register
   logic out_adv, s4_adv, s3_adv, s2_adv, s1_adv;

   assign out_adv   = !out_v_ff || rsp_ready;
   assign s4_adv    = !s4_v_ff || out_adv;
   assign s3_adv    = !s3_v_ff || !s3_last_ff || s4_adv;
   assign s2_adv    = !s2_v_ff || s3_adv;
   assign s1_adv    = !s1_v_ff || s2_adv;
   assign req_ready = s1_adv;

   // datapath next values
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  run_in;
   scale_type                sum_scaled, bias_scaled, base_in;
   logic signed [TOTAL_W-1:0] total;
   logic signed [DATA_W-1:0] result_in;

   assign prod_in = s1_weight_ff * s1_act_ff;
   assign run_in  = (s2_first_ff ? SUM_W'(0) : run_ff) + SUM_W'(s2_prod_ff);

   qcmr_rescale u_sum_rescale (
      .x  (SCALE_W'(run_ff)),
      .sh (out_sh),
      .y  (sum_scaled)
   );

   qcmr_rescale u_bias_rescale (
      .x  (SCALE_W'(s3_bias_ff)),
      .sh (bias_sh),
      .y  (bias_scaled)
   );

   assign base_in = s3_use_bias_ff ? bias_scaled : SCALE_W'(s3_prior_ff);

   // add base and saturate to int16
   always_comb begin
      total = TOTAL_W'(s4_scaled_ff) + TOTAL_W'(s4_base_ff);
      if (total > TOTAL_W'(RES_MAX)) begin
         result_in = DATA_W'(RES_MAX);
      end else if (total < TOTAL_W'(RES_MIN)) begin
         result_in = DATA_W'(RES_MIN);
      end else begin
         result_in = total[DATA_W-1:0];
      end
   end

   // valid bits and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         run_ff   <= '0;
      end else begin
         if (s1_adv)  s1_v_ff  <= req_valid;
         if (s2_adv)  s2_v_ff  <= s1_v_ff;
         if (s3_adv)  s3_v_ff  <= s2_v_ff;
         if (s4_adv)  s4_v_ff  <= s3_v_ff && s3_last_ff;
         if (out_adv) out_v_ff <= s4_v_ff;
         if (s3_adv && s2_v_ff) run_ff <= run_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         s1_weight_ff   <= req_weight;
         s1_act_ff      <= req_activation;
         s1_first_ff    <= req_first_term;
         s1_last_ff     <= req_last_term;
         s1_use_bias_ff <= req_use_bias;
         s1_bias_ff     <= req_bias;
         s1_prior_ff    <= req_prior_output;
      end
      if (s2_adv && s1_v_ff) begin
         s2_prod_ff     <= prod_in;
         s2_first_ff    <= s1_first_ff;
         s2_last_ff     <= s1_last_ff;
         s2_use_bias_ff <= s1_use_bias_ff;
         s2_bias_ff     <= s1_bias_ff;
         s2_prior_ff    <= s1_prior_ff;
      end
      if (s3_adv && s2_v_ff) begin
         s3_last_ff     <= s2_last_ff;
         s3_use_bias_ff <= s2_use_bias_ff;
         s3_bias_ff     <= s2_bias_ff;
         s3_prior_ff    <= s2_prior_ff;
      end
      if (s4_adv && s3_v_ff && s3_last_ff) begin
         s4_scaled_ff <= sum_scaled;
         s4_base_ff   <= base_in;
      end
      if (out_adv && s4_v_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_result = result_ff;

   // only a last word may fill the rescale stage
   a_s4_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(s4_v_ff) |-> $past(s3_v_ff && s3_last_ff))
      else $error("rescale stage filled by a word not marked last");

   // the running sum moves only when a term enters the sum stage
   a_run_stable: assert property (@(posedge clock) disable iff (reset)
      !(s3_adv && s2_v_ff) |=> $stable(run_ff))
      else $error("running sum changed without a term");

   // a blocked rescale stage keeps its contents
   a_s4_hold: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && !out_adv) |=> (s4_v_ff && $stable(s4_scaled_ff) && $stable(s4_base_ff)))
      else $error("rescale stage overwritten while blocked");

endmodule

[tb/quantized_conv_mac_rescale_top_tb.sv]
`timescale 1ns / 1ps

module quantized_conv_mac_rescale_top_tb;
   import qcmr_pkg::*;

   localparam int DRAIN_CYCLES  = 8;
   localparam int WORDS_PER_CFG = 64;

   // one multiply-accumulate word as the sender sees it
   typedef struct {
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] activation;
      logic                     first_term;
      logic                     last_term;
      logic                     use_bias;
      logic signed [DATA_W-1:0] bias;
      logic signed [DATA_W-1:0] prior_output;
   } mac_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_weight = '0;
   logic signed [DATA_W-1:0] req_activation = '0;
   logic                     req_first_term = 1'b0;
   logic                     req_last_term = 1'b0;
   logic                     req_use_bias = 1'b0;
   logic signed [DATA_W-1:0] req_bias = '0;
   logic signed [DATA_W-1:0] req_prior_output = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_result;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [FRAC_W-1:0]        csr_wdata = '0;

   // model copy of the csrs and the accumulator
   int                      weight_frac;
   int                      act_in_frac;
   int                      act_out_frac;
   int                      bias_frac;
   logic signed [SUM_W-1:0] mac_sum;

   logic signed [DATA_W-1:0] pending_results[$];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int configs_used    = 0;
   int fail_count      = 0;

   quantized_conv_mac_rescale_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_weight       (req_weight),
      .req_activation   (req_activation),
      .req_first_term   (req_first_term),
      .req_last_term    (req_last_term),
      .req_use_bias     (req_use_bias),
      .req_bias         (req_bias),
      .req_prior_output (req_prior_output),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #(20 * 400000);
      $display("Mismatches found");
      $finish;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // shift by a signed amount, positive is right with round half up, left saturates
   function automatic longint requantize(input longint x, input int sh);
      int     mag;
      longint lim;
      longint cap;
      if (sh == 0) return x;
      mag = (sh > 0) ? sh : -sh;
      if (mag > SHIFT_CAP) mag = SHIFT_CAP;
      if (sh > 0) return (x + (longint'(1) <<< (mag - 1))) >>> mag;
      cap = longint'(1) <<< LSH_LIMIT_LOG;
      lim = cap >>> mag;
      if (x > lim) return cap;
      if (x < -lim) return -cap;
      return x <<< mag;
   endfunction

   // accumulate one word and queue the rescaled output on a last word
   task automatic mac_requant_step(input mac_word_type wd);
      longint prod;
      longint base;
      longint total;
      int     out_sh;
      int     bias_sh;
      prod = longint'(wd.weight) * longint'(wd.activation);
      if (wd.first_term) mac_sum = '0;
      mac_sum = mac_sum + prod[SUM_W-1:0];
      if (wd.last_term) begin
         out_sh  = act_in_frac + weight_frac - act_out_frac;
         bias_sh = bias_frac - act_out_frac;
         base = wd.use_bias ? requantize(longint'(wd.bias), bias_sh)
                            : longint'(wd.prior_output);
         total = base + requantize(longint'(mac_sum), out_sh);
         if (total > RES_MAX) total = RES_MAX;
         if (total < RES_MIN) total = RES_MIN;
         pending_results.push_back(total[DATA_W-1:0]);
      end
   endtask

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result: unexpected word, actual %0d", rsp_result);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_result !== want) begin
               $error("result: expected %0d, actual %0d", want, rsp_result);
               fail_count++;
            end
         end
      end
   end

   function automatic mac_word_type mk_word(input logic signed [DATA_W-1:0] w,
                                            input logic signed [DATA_W-1:0] a,
                                            input logic first, input logic last,
                                            input logic ub,
                                            input logic signed [DATA_W-1:0] b,
                                            input logic signed [DATA_W-1:0] prior);
      mac_word_type wd;
      wd.weight       = w;
      wd.activation   = a;
      wd.first_term   = first;
      wd.last_term    = last;
      wd.use_bias     = ub;
      wd.bias         = b;
      wd.prior_output = prior;
      return wd;
   endfunction

   // send one word; entered and left at a falling edge
   task automatic send_word(input mac_word_type wd);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_weight       <= wd.weight;
      req_activation   <= wd.activation;
      req_first_term   <= wd.first_term;
      req_last_term    <= wd.last_term;
      req_use_bias     <= wd.use_bias;
      req_bias         <= wd.bias;
      req_prior_output <= wd.prior_output;
      do @(posedge clock); while (!(req_valid && req_ready));
      mac_requant_step(wd);
      words_sent++;
      @(negedge clock);
   endtask

   // hold the sender off until every predicted result has come back
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write all four csrs back to back, only while idle
   task automatic set_config(input int w, input int ai, input int ao, input int b);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WEIGHT_FRAC;
      csr_wdata <= FRAC_W'(w);
      @(negedge clock);
      csr_index <= CSR_ACT_IN_FRAC;
      csr_wdata <= FRAC_W'(ai);
      @(negedge clock);
      csr_index <= CSR_ACT_OUT_FRAC;
      csr_wdata <= FRAC_W'(ao);
      @(negedge clock);
      csr_index <= CSR_BIAS_FRAC;
      csr_wdata <= FRAC_W'(b);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      weight_frac  = w;
      act_in_frac  = ai;
      act_out_frac = ao;
      bias_frac    = b;
      configs_used++;
      @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_operand();
      case ($urandom_range(7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return DATA_W'($signed($urandom_range(31)) - 16);
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // reset csr values: no shift; field extremes, both bases, sum kept past last
   task automatic test_directed_extremes;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      send_word(mk_word(16'sh7fff, 16'sh7fff, 1, 1, 1, 16'sh7fff, 16'sh0000));
      send_word(mk_word(16'sh8000, 16'sh7fff, 1, 1, 0, 16'sh0000, 16'sh8000));
      send_word(mk_word(16'sh8000, 16'sh8000, 1, 1, 1, 16'sh8000, 16'sh7fff));
      send_word(mk_word(16'sh0000, 16'sh0000, 1, 1, 0, 16'sh7fff, 16'sh0000));
      // three-term sum, then one more term without first keeps accumulating
      send_word(mk_word(16'sd1, 16'sd5, 1, 0, 0, 16'sd0, 16'sd0));
      send_word(mk_word(16'sd2, 16'sd3, 0, 0, 0, 16'sd0, 16'sd0));
      send_word(mk_word(16'sd1, 16'sd1, 0, 1, 0, 16'sd0, 16'sd100));
      send_word(mk_word(16'sd1, 16'sd1, 0, 1, 1, -16'sd20, 16'sd0));
   endtask

   // shift right by one on both paths: ties round toward plus infinity
   task automatic test_rounding;
      drain();
      set_config(1, 0, 0, 1);
      send_word(mk_word(16'sd1, 16'sd1, 1, 1, 1, 16'sd1, 16'sd0));
      send_word(mk_word(-16'sd1, 16'sd1, 1, 1, 1, -16'sd1, 16'sd0));
      send_word(mk_word(16'sd3, 16'sd1, 1, 1, 1, 16'sd3, 16'sd0));
      send_word(mk_word(-16'sd3, 16'sd1, 1, 1, 1, -16'sd3, 16'sd0));
   endtask

   // shift magnitudes past the cap, left shift overflow, moderate left shift
   task automatic test_shift_clamp;
      drain();
      set_config(31, 31, 0, 31);
      send_word(mk_word(16'sh7fff, 16'sh7fff, 1, 1, 1, 16'sh7fff, 16'sd0));
      send_word(mk_word(16'sh8000, 16'sh7fff, 1, 1, 0, 16'sd0, 16'sd5));
      drain();
      set_config(0, 0, 31, 0);
      send_word(mk_word(16'sd1, 16'sd1, 1, 1, 0, 16'sd0, 16'sh8000));
      send_word(mk_word(16'sh7fff, 16'sd64, 1, 1, 0, 16'sd0, 16'sd0));
      send_word(mk_word(16'sh8000, 16'sh7fff, 1, 1, 0, 16'sd0, 16'sh7fff));
      send_word(mk_word(16'sd0, 16'sd0, 1, 1, 1, -16'sd1, 16'sd0));
      send_word(mk_word(16'sd0, 16'sd0, 1, 1, 1, 16'sd0, 16'sd0));
      drain();
      set_config(0, 0, 3, 0);
      send_word(mk_word(16'sd3, -16'sd5, 1, 1, 1, -16'sd7, 16'sd0));
   endtask

   // full-scale products until the 40-bit sum wraps; a shift of 30 shows the count
   task automatic test_sum_wrap;
      int k;
      drain();
      set_config(15, 15, 0, 0);
      sender_idle_pct = 12;
      rsp_stall_pct   = 12;
      for (k = 1; k <= 520; k++) begin
         send_word(mk_word(16'sh8000, 16'sh8000, k == 1,
                           (k == 511) || (k == 512) || (k == 520), 0, 16'sd0, 16'sd0));
      end
   endtask

   function automatic int pick_frac(input int mode);
      case (mode)
         0: return $urandom_range(31);
         1: return $urandom_range(1) ? 31 : 0;
         default: return $urandom_range(8, 15);
      endcase
   endfunction

   // mostly well-formed term groups, the rest loose words with random flags
   task automatic run_term_groups(input int n_words);
      int sent;
      int len;
      int k;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(99) < 85) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, TERMS_MAX)
                                           : $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
               send_word(mk_word(pick_operand(), pick_operand(), k == 0, k == len - 1,
                                 1'($urandom_range(1)), pick_operand(), pick_operand()));
            end
            sent += len;
         end else begin
            send_word(mk_word(pick_operand(), pick_operand(), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              pick_operand(), pick_operand()));
            sent++;
         end
      end
   endtask

   // four handshake pressure phases, four csr settings each
   task automatic test_random_traffic;
      int phase;
      int c;
      int mode;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 80; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 80; end
            default: begin sender_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         for (c = 0; c < 4; c++) begin
            drain();
            mode = $urandom_range(2);
            if (mode == 2)
               set_config(pick_frac(2), pick_frac(2), $urandom_range(3), $urandom_range(8));
            else
               set_config(pick_frac(mode), pick_frac(mode), pick_frac(mode), pick_frac(mode));
            run_term_groups(WORDS_PER_CFG);
         end
      end
   endtask

   initial begin
      weight_frac  = 0;
      act_in_frac  = 0;
      act_out_frac = 0;
      bias_frac    = 0;
      mac_sum      = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_rounding();
      test_shift_clamp();
      test_sum_wrap();
      test_random_traffic();
      drain();

      $display("covered %0d words and %0d checked results over %0d csr settings,",
               words_sent, results_checked, configs_used);
      $display("with sender gaps and receiver stalls in four pressure phases");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
rtl/qcmr_pkg.sv
rtl/qcmr_rescale.sv
rtl/quantized_conv_mac_rescale_top.sv
tb/quantized_conv_mac_rescale_top_tb.sv
